/* rtl/lssf_pkg.sv */
// shared types and constants of the local supervision status block
`timescale 1ns / 1ps

package lssf_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FAILED  = 2'd1,
    ST_EXPIRED = 2'd2,
    ST_DEACT   = 2'd3
  } sup_state_t;

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_MODE   = 1'b1;

  localparam logic [1:0] KIND_ALIVE    = 2'd0;
  localparam logic [1:0] KIND_DEADLINE = 2'd1;
  localparam logic [1:0] KIND_LOGICAL  = 2'd2;

  localparam int CNT_W   = 17;
  localparam int TOL_W   = 16;
  localparam int TAG_W   = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = 17'd65536;

  typedef struct packed {
    logic             opcode;
    logic [1:0]       check_kind;
    logic             check_correct;
    logic             any_active;
    logic             alive_incorrect;
    logic             timing_incorrect;
    logic [TAG_W-1:0] process_tag;
    logic [TAG_W-1:0] cluster_tag;
  } item_t;

  typedef struct packed {
    sup_state_t       status;
    logic [CNT_W-1:0] fail_count;
    logic             notify;
    logic [1:0]       notify_kind;
    logic [TAG_W-1:0] notify_process;
    logic [TAG_W-1:0] notify_cluster;
  } result_t;

  // handshake between the input register and the result register
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

/* rtl/lssf_in_stage.sv */
// input register stage holding one accepted item
`timescale 1ns / 1ps

module lssf_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lssf_pkg::item_t     item_in,
  input  logic                advance,
  output logic                hold_valid,
  output lssf_pkg::item_t     item_q
);

  logic valid_q;

  // free when empty or when the held item moves on this cycle
  assign in_ready   = !valid_q || advance;
  assign hold_valid = valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= item_in;
    end
  end

endmodule

/* rtl/lssf_core.sv */
// supervision state machine with failure counter and tolerance register
`timescale 1ns / 1ps

module lssf_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [lssf_pkg::TOL_W-1:0]          cfg_wr_data,
  input  lssf_pkg::stage_ctl_t                ctl,
  input  lssf_pkg::item_t                     item,
  output lssf_pkg::result_t                   res
);

  lssf_pkg::sup_state_t               state;
  lssf_pkg::sup_state_t               state_next;
  logic [lssf_pkg::CNT_W-1:0]         fail_counter;
  logic [lssf_pkg::CNT_W-1:0]         fail_counter_next;
  logic [lssf_pkg::TOL_W-1:0]         failure_tolerance;
  logic [lssf_pkg::CNT_W-1:0]         tol_ext;
  logic [lssf_pkg::CNT_W-1:0]         cnt_inc;
  logic [lssf_pkg::CNT_W-1:0]         cnt_dec;
  logic                               notify;
  logic                               timing_kind;

  assign tol_ext     = {1'b0, failure_tolerance};
  assign cnt_inc     = (fail_counter == lssf_pkg::CNT_MAX) ? fail_counter
                                                           : fail_counter + 1'b1;
  assign cnt_dec     = (fail_counter == '0) ? fail_counter : fail_counter - 1'b1;
  assign timing_kind = (item.check_kind == lssf_pkg::KIND_DEADLINE) ||
                       (item.check_kind == lssf_pkg::KIND_LOGICAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= lssf_pkg::ST_DEACT;
      fail_counter      <= '0;
      failure_tolerance <= '0;
    end else begin
      if (cfg_wr_en) begin
        failure_tolerance <= cfg_wr_data;
      end
      if (ctl.advance) begin
        state        <= state_next;
        fail_counter <= fail_counter_next;
      end
    end
  end

  always_comb begin
    state_next        = state;
    fail_counter_next = fail_counter;
    notify            = 1'b0;
    if (item.opcode == lssf_pkg::OP_MODE) begin
      if (!item.any_active) begin
        state_next        = lssf_pkg::ST_DEACT;
        fail_counter_next = '0;
      end else begin
        unique case (state)
          lssf_pkg::ST_DEACT: begin
            state_next = lssf_pkg::ST_OK;
          end
          lssf_pkg::ST_FAILED: begin
            if (!item.alive_incorrect) begin
              state_next        = lssf_pkg::ST_OK;
              fail_counter_next = '0;
            end
          end
          lssf_pkg::ST_EXPIRED: begin
            // recover only when nothing keeps the supervision expired
            if (!(item.timing_incorrect ||
                  (item.alive_incorrect && fail_counter >= tol_ext))) begin
              state_next        = lssf_pkg::ST_OK;
              fail_counter_next = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (state != lssf_pkg::ST_EXPIRED) begin
      notify = 1'b1;
      if (timing_kind) begin
        if (!item.check_correct) begin
          state_next = lssf_pkg::ST_EXPIRED;
        end
      end else if (state == lssf_pkg::ST_FAILED) begin
        if (item.check_correct) begin
          if (fail_counter <= 17'd1) begin
            state_next = lssf_pkg::ST_OK;
          end
          fail_counter_next = cnt_dec;
        end else if (fail_counter < tol_ext) begin
          fail_counter_next = cnt_inc;
        end else begin
          state_next = lssf_pkg::ST_EXPIRED;
        end
      end else if (item.check_correct) begin
        state_next = lssf_pkg::ST_OK;
      end else if (failure_tolerance == '0) begin
        state_next = lssf_pkg::ST_EXPIRED;
      end else begin
        state_next        = lssf_pkg::ST_FAILED;
        fail_counter_next = cnt_inc;
      end
    end

    res.status         = state_next;
    res.fail_count     = fail_counter_next;
    res.notify         = notify;
    res.notify_kind    = notify ? item.check_kind : 2'd0;
    res.notify_process = notify ? item.process_tag : '0;
    res.notify_cluster = notify ? item.cluster_tag : '0;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    fail_counter <= lssf_pkg::CNT_MAX)
    else $error("failure counter above saturation limit");

  a_deact_clear: assert property (@(posedge clk) disable iff (rst)
    state == lssf_pkg::ST_DEACT |-> fail_counter == '0)
    else $error("counter nonzero while deactivated");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !ctl.advance |=> $stable(state) && $stable(fail_counter))
    else $error("state changed without an item");

  a_mode_off: assert property (@(posedge clk) disable iff (rst)
    ctl.advance && item.opcode == lssf_pkg::OP_MODE && !item.any_active
    |=> state == lssf_pkg::ST_DEACT && fail_counter == '0)
    else $error("inactive mode switch did not deactivate");

  a_adv_valid: assert property (@(posedge clk) disable iff (rst)
    ctl.advance |-> ctl.valid)
    else $error("advance without a held item");
`endif

endmodule

/* rtl/lssf_out_stage.sv */
// result register stage facing the output channel
`timescale 1ns / 1ps

module lssf_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                hold_valid,
  input  lssf_pkg::result_t   res,
  output lssf_pkg::stage_ctl_t ctl,
  output logic                out_valid,
  input  logic                out_ready,
  output lssf_pkg::result_t   res_q
);

  logic valid_q;
  logic take;

  // room when empty or when the receiver takes the current result
  assign take        = !valid_q || out_ready;
  assign ctl.valid   = hold_valid;
  assign ctl.advance = hold_valid && take;
  assign out_valid   = valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      res_q <= res;
    end
  end

endmodule

/* rtl/local_supervision_status_fsm.sv */
// top level of the local supervision status block
//
// input channel: in_valid/in_ready carry one item, either a base check report
// (opcode 0) or a mode switch summary (opcode 1). output channel:
// out_valid/out_ready carry exactly one result item per input item, in order:
// the state and failure counter after the item plus the notification echo.
// the tolerance register is written by cfg_wr_en/cfg_wr_data with no wait;
// write it only while no item is in flight.
// an accepted item is held in the input register and its result is registered
// in the result register, whose valid flag drives out_valid.
// throughput: one item per cycle unless the receiver stalls; the state and
// counter update in the single compare-and-select pass between the registers.
// reset (rst, synchronous) empties both registers, sets the state to
// deactivated, the counter to zero and the tolerance to zero.
// when the receiver stalls the result register holds, the input register
// fills behind it and in_ready falls until out_ready returns.
`timescale 1ns / 1ps

module local_supervision_status_fsm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [lssf_pkg::TOL_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic [1:0]                   check_kind,
  input  logic                         check_correct,
  input  logic                         any_active,
  input  logic                         alive_incorrect,
  input  logic                         timing_incorrect,
  input  logic [lssf_pkg::TAG_W-1:0]   process_tag,
  input  logic [lssf_pkg::TAG_W-1:0]   cluster_tag,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [lssf_pkg::CNT_W-1:0]   fail_count,
  output logic                         notify,
  output logic [1:0]                   notify_kind,
  output logic [lssf_pkg::TAG_W-1:0]   notify_process,
  output logic [lssf_pkg::TAG_W-1:0]   notify_cluster
);

  lssf_pkg::item_t      item_in;
  lssf_pkg::item_t      item_q;
  lssf_pkg::result_t    res;
  lssf_pkg::result_t    res_q;
  lssf_pkg::stage_ctl_t ctl;
  logic                 hold_valid;

  assign item_in.opcode           = opcode;
  assign item_in.check_kind       = check_kind;
  assign item_in.check_correct    = check_correct;
  assign item_in.any_active       = any_active;
  assign item_in.alive_incorrect  = alive_incorrect;
  assign item_in.timing_incorrect = timing_incorrect;
  assign item_in.process_tag      = process_tag;
  assign item_in.cluster_tag      = cluster_tag;

  lssf_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_in    (item_in),
    .advance    (ctl.advance),
    .hold_valid (hold_valid),
    .item_q     (item_q)
  );

  lssf_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .item        (item_q),
    .res         (res)
  );

  lssf_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .hold_valid (hold_valid),
    .res        (res),
    .ctl        (ctl),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res_q      (res_q)
  );

  assign status         = res_q.status;
  assign fail_count     = res_q.fail_count;
  assign notify         = res_q.notify;
  assign notify_kind    = res_q.notify_kind;
  assign notify_process = res_q.notify_process;
  assign notify_cluster = res_q.notify_cluster;

endmodule
